>>> hdl/assert_macros.svh
// assertion macros shared by the dxt1 block decoder files
// depends on nothing; expects a clock named i_clk and a reset named i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, switched off while reset is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hdl/dxt1_pkg.sv
// types and constants of the dxt1 block color decoder
// depends on nothing
package dxt1_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RGB565_MODE   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SWAP_CHANNELS = 1'd1;
    localparam int CFG_DATA_W = 1;

    // reset values of the configuration registers
    localparam logic RGB565_MODE_RST   = 1'b1;
    localparam logic SWAP_CHANNELS_RST = 1'b0;

    // block geometry
    localparam int PIXELS    = 16;
    localparam int PIX_NUM_W = 4;
    localparam logic [PIX_NUM_W-1:0] LAST_PIX = 4'd15;

    // palette codes
    localparam logic [1:0] PAL_C0 = 2'd0;
    localparam logic [1:0] PAL_C1 = 2'd1;
    localparam logic [1:0] PAL_C2 = 2'd2;
    localparam logic [1:0] PAL_C3 = 2'd3;

    // reciprocal of three: floor(x * 683 / 2048) == floor(x / 3) for x below 1024
    localparam logic [9:0] RECIP3     = 10'd683;
    localparam int         RECIP3_SHR = 11;

    // one input word: one compressed block
    typedef struct packed {
        logic [15:0] color_zero;
        logic [15:0] color_one;
        logic [31:0] pixel_indices;
    } t_in_word;

    // one output word: one decoded pixel
    typedef struct packed {
        logic [3:0] pixel_number;
        logic [7:0] low_channel;
        logic [7:0] mid_channel;
        logic [7:0] high_channel;
        logic       last_pixel;
    } t_out_word;

    // one color split into channel fields, not yet widened
    typedef struct packed {
        logic [5:0] hi;
        logic [5:0] mid;
        logic [5:0] lo;
    } t_chan;

endpackage

>>> hdl/dxt1_block_color_decoder_top.sv
// dxt1 block color decoder: one 4x4 block in, sixteen 8-bit-per-channel pixels out
// depends on dxt1_pkg and assert_macros.svh
`include "assert_macros.svh"

// A block is taken at a rising edge where start is high and busy is low; its sixteen
// pixels come out in row-major order on consecutive cycles, each marked by
// o_strobe for one cycle, with last_pixel set on pixel 15. The receiver cannot stall:
// every strobed word must be taken. A block passes through the unpack stage, the
// palette stage, the pixel serializer and the output register. The serializer sends
// one pixel per cycle; a new block is taken while the previous one is still being
// decoded or sent, busy is high only when the two front stages already hold blocks
// waiting for the serializer. Configuration writes must be made while no block is
// in flight.
module dxt1_block_color_decoder_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  dxt1_pkg::t_in_word                   i_block,
    output logic                                 o_strobe,
    output dxt1_pkg::t_out_word                  o_result,
    input  logic                                 i_cfg_we,
    input  logic [dxt1_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [dxt1_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import dxt1_pkg::*;

    // split a packed color into channel fields, swapping high and low if asked
    function automatic t_chan unpack(input logic [15:0] c, input logic m565,
                                     input logic swap);
        t_chan r;
        logic [5:0] hi, lo;
        begin
            hi = m565 ? {1'b0, c[15:11]} : {1'b0, c[14:10]};
            lo = {1'b0, c[4:0]};
            r.mid = m565 ? c[10:5] : {1'b0, c[9:5]};
            r.hi  = swap ? lo : hi;
            r.lo  = swap ? hi : lo;
            return r;
        end
    endfunction

    // rounded thirds: (2p + q + 1) / 3
    function automatic logic [5:0] third_of(input logic [5:0] p, input logic [5:0] q);
        logic [7:0]  s;
        logic [17:0] prod;
        begin
            s    = {1'b0, p, 1'b0} + {2'b00, q} + 8'd1;
            prod = {10'd0, s} * {8'd0, RECIP3};
            return prod[RECIP3_SHR +: 6];
        end
    endfunction

    // rounded half sum
    function automatic logic [5:0] half_of(input logic [5:0] p, input logic [5:0] q);
        logic [6:0] s;
        begin
            s = {1'b0, p} + {1'b0, q} + 7'd1;
            return s[6:1];
        end
    endfunction

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    // configuration registers
    logic r_rgb565_mode;
    logic r_swap_channels;

    // stage 1: unpacked endpoints
    logic        r_s1_valid;
    t_chan       r_s1_ca, r_s1_cb;
    logic        r_s1_third;
    logic        r_s1_565;
    logic [31:0] r_s1_idx;

    // stage 2: palette
    logic        r_s2_valid;
    t_chan       r_s2_pal [4];
    logic        r_s2_565;
    logic [31:0] r_s2_idx;

    // stage 3: pixel serializer
    logic                 r_ser_valid;
    logic [PIX_NUM_W-1:0] r_ser_cnt;
    t_chan                r_ser_pal [4];
    logic                 r_ser_565;
    logic [31:0]          r_ser_idx;

    // stage 4: output register
    logic      r_out_valid;
    t_out_word r_out;

    logic  accept, s1_move, ser_load, ser_last;
    t_chan n_pal [4];
    t_chan sel;

    // stage handshakes
    always_comb begin
        ser_last = r_ser_valid && (r_ser_cnt == LAST_PIX);
        ser_load = r_s2_valid && (!r_ser_valid || ser_last);
        s1_move  = r_s1_valid && (!r_s2_valid || ser_load);
        busy     = r_s1_valid && !s1_move;
        accept   = start && !busy;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rgb565_mode   <= RGB565_MODE_RST;
            r_swap_channels <= SWAP_CHANNELS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RGB565_MODE:   r_rgb565_mode   <= i_cfg_data[0];
                CFG_SWAP_CHANNELS: r_swap_channels <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // palette per channel
    always_comb begin
        n_pal[PAL_C0] = r_s1_ca;
        n_pal[PAL_C1] = r_s1_cb;
        if (r_s1_third) begin
            n_pal[PAL_C2].lo  = third_of(r_s1_ca.lo,  r_s1_cb.lo);
            n_pal[PAL_C2].mid = third_of(r_s1_ca.mid, r_s1_cb.mid);
            n_pal[PAL_C2].hi  = third_of(r_s1_ca.hi,  r_s1_cb.hi);
            n_pal[PAL_C3].lo  = third_of(r_s1_cb.lo,  r_s1_ca.lo);
            n_pal[PAL_C3].mid = third_of(r_s1_cb.mid, r_s1_ca.mid);
            n_pal[PAL_C3].hi  = third_of(r_s1_cb.hi,  r_s1_ca.hi);
        end else begin
            n_pal[PAL_C2].lo  = half_of(r_s1_ca.lo,  r_s1_cb.lo);
            n_pal[PAL_C2].mid = half_of(r_s1_ca.mid, r_s1_cb.mid);
            n_pal[PAL_C2].hi  = half_of(r_s1_ca.hi,  r_s1_cb.hi);
            n_pal[PAL_C3]     = '0;
        end
    end

    // current pixel's palette entry
    always_comb begin
        sel = r_ser_pal[r_ser_idx[1:0]];
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_ser_valid <= 1'b0;
            r_ser_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_s2_valid <= 1'b1;
            end else if (ser_load) begin
                r_s2_valid <= 1'b0;
            end
            if (ser_load) begin
                r_ser_valid <= 1'b1;
                r_ser_cnt   <= '0;
            end else if (r_ser_valid) begin
                r_ser_valid <= !ser_last;
                r_ser_cnt   <= r_ser_cnt + 4'd1;
            end
            r_out_valid <= r_ser_valid;
        end
    end

    // data path registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ca    <= unpack(i_block.color_zero, r_rgb565_mode, r_swap_channels);
            r_s1_cb    <= unpack(i_block.color_one,  r_rgb565_mode, r_swap_channels);
            r_s1_third <= i_block.color_zero > i_block.color_one;
            r_s1_565   <= r_rgb565_mode;
            r_s1_idx   <= i_block.pixel_indices;
        end
        if (s1_move) begin
            r_s2_pal <= n_pal;
            r_s2_565 <= r_s1_565;
            r_s2_idx <= r_s1_idx;
        end
        if (ser_load) begin
            r_ser_pal <= r_s2_pal;
            r_ser_565 <= r_s2_565;
            r_ser_idx <= r_s2_idx;
        end else if (r_ser_valid) begin
            r_ser_idx <= {2'b00, r_ser_idx[31:2]};
        end
        r_out.pixel_number <= r_ser_cnt;
        r_out.low_channel  <= widen5(sel.lo[4:0]);
        r_out.mid_channel  <= r_ser_565 ? widen6(sel.mid) : widen5(sel.mid[4:0]);
        r_out.high_channel <= widen5(sel.hi[4:0]);
        r_out.last_pixel   <= r_ser_cnt == LAST_PIX;
    end

    assign o_strobe = r_out_valid;
    assign o_result = r_out;

    // checks
    `ASSERT_CLK(a_accept_fills_s1, (start && !busy) |=> r_s1_valid, "accepted block lost")
    `ASSERT_CLK(a_ser_runs, (r_ser_valid && r_ser_cnt != LAST_PIX) |=> r_ser_valid,
        "serializer stopped inside a block")
    `ASSERT_CLK(a_pixel_seq, (o_strobe && !o_result.last_pixel) |=>
        (o_strobe && o_result.pixel_number == 4'($past(o_result.pixel_number) + 4'd1)),
        "pixel sequence broken")
    `ASSERT_CLK(a_last_flag, o_strobe |->
        (o_result.last_pixel == (o_result.pixel_number == LAST_PIX)),
        "last pixel flag misplaced")

endmodule
